### hdl/ffec_pkg.sv
package ffec_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int DUTY_W         = 10;
	localparam int BUTTON_W       = 3;
	localparam int FLOOR_W        = 3;
	localparam int MASK_W         = 4;
	localparam int LED_W          = 8;
	localparam int PHASE_W        = 4;
	localparam int DIR_W          = 2;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_PRE_CLOSE = 3'd0;
	localparam logic [2:0] REG_DOOR_TIME = 3'd1;
	localparam logic [2:0] REG_TRAVEL    = 3'd2;
	localparam logic [2:0] REG_DWELL     = 3'd3;
	localparam logic [2:0] REG_FLOW      = 3'd4;
	localparam logic [2:0] REG_UP_DUTY   = 3'd5;
	localparam logic [2:0] REG_DOWN_DUTY = 3'd6;

	localparam logic [CFG_W-1:0]  PRE_CLOSE_RST = 16'd1000;
	localparam logic [CFG_W-1:0]  DOOR_TIME_RST = 16'd4000;
	localparam logic [CFG_W-1:0]  TRAVEL_RST    = 16'd6000;
	localparam logic [CFG_W-1:0]  DWELL_RST     = 16'd2000;
	localparam logic [CFG_W-1:0]  FLOW_RST      = 16'd300;
	localparam logic [DUTY_W-1:0] UP_DUTY_RST   = 10'd800;
	localparam logic [DUTY_W-1:0] DOWN_DUTY_RST = 10'd600;

	localparam logic [DUTY_W-1:0] DOOR_CLOSE_DUTY = 10'd250;
	localparam logic [DUTY_W-1:0] DOOR_OPEN_DUTY  = 10'd300;

	localparam logic [LED_W-1:0] FLOW_START = 8'h10;
	localparam logic [LED_W-1:0] FLOW_WRAP  = 8'h08;
	localparam logic [LED_W-1:0] FLOW_TOP   = 8'h80;
	localparam logic [LED_W-1:0] LED_HI     = 8'hF0;
	localparam logic [LED_W-1:0] LED_LO     = 8'h0F;

	localparam logic [FLOOR_W-1:0] FLOOR_BOTTOM = 3'd1;
	localparam logic [FLOOR_W-1:0] FLOOR_TOP    = 3'd4;
	localparam logic [BUTTON_W-1:0] BUTTON_NONE = 3'd0;
	localparam logic [BUTTON_W-1:0] BUTTON_MAX  = 3'd4;

	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

	localparam logic [PHASE_W-1:0] PCODE_IDLE   = 4'd0;
	localparam logic [PHASE_W-1:0] PCODE_START  = 4'd1;
	localparam logic [PHASE_W-1:0] PCODE_CLOSE  = 4'd2;
	localparam logic [PHASE_W-1:0] PCODE_CHOOSE = 4'd3;
	localparam logic [PHASE_W-1:0] PCODE_TRAVEL = 4'd4;
	localparam logic [PHASE_W-1:0] PCODE_ARRIVE = 4'd5;
	localparam logic [PHASE_W-1:0] PCODE_OPEN   = 4'd6;
	localparam logic [PHASE_W-1:0] PCODE_MORE   = 4'd7;
	localparam logic [PHASE_W-1:0] PCODE_DWELL  = 4'd8;

	typedef enum logic [8:0] {
		PH_IDLE   = 9'b000000001,
		PH_START  = 9'b000000010,
		PH_CLOSE  = 9'b000000100,
		PH_CHOOSE = 9'b000001000,
		PH_TRAVEL = 9'b000010000,
		PH_ARRIVE = 9'b000100000,
		PH_OPEN   = 9'b001000000,
		PH_MORE   = 9'b010000000,
		PH_DWELL  = 9'b100000000
	} phase_t;

endpackage

### hdl/ffec_cmd_if.sv
interface ffec_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ffec_pkg::BUTTON_W-1:0] button;

	modport source (output valid, output button, input ready);
	modport sink (input valid, input button, output ready);
endinterface

### hdl/ffec_res_if.sv
interface ffec_res_if;
	logic                         valid;
	logic                         ready;
	logic [ffec_pkg::FLOOR_W-1:0] floor;
	logic [ffec_pkg::MASK_W-1:0]  request_mask;
	logic [ffec_pkg::LED_W-1:0]   led_pattern;
	logic [ffec_pkg::PHASE_W-1:0] phase;
	logic                         door_pwm_on;
	logic [ffec_pkg::DUTY_W-1:0]  door_duty;
	logic                         door_open_level;
	logic                         motor_pwm_on;
	logic [ffec_pkg::DUTY_W-1:0]  motor_duty;
	logic                         motor_up_level;

	modport source (output valid, output floor, output request_mask, output led_pattern,
		output phase, output door_pwm_on, output door_duty, output door_open_level,
		output motor_pwm_on, output motor_duty, output motor_up_level, input ready);
	modport sink (input valid, input floor, input request_mask, input led_pattern,
		input phase, input door_pwm_on, input door_duty, input door_open_level,
		input motor_pwm_on, input motor_duty, input motor_up_level, output ready);
endinterface

### hdl/four_floor_elevator_controller_unit.sv
// channel  | direction | payload                               | transaction
// ---------+-----------+---------------------------------------+---------------------------
// cmd      | in        | button (one tick)                     | valid & ready
// res      | out       | floor, masks, phase, door/motor drive | valid & ready
// apb      | in        | 7 registers at 4*i                    | psel & penable & pwrite
//
// one tick per cycle unless res stalls: a tick waits in the input register, and the whole
// sequencer pass for it lands in the state registers, which are also the result.
// res valid passes the input register, then res_valid_q; a held result stalls both.
// cmd stalls only while a result is waiting and the input register is full.
// reset puts the car idle on floor 1 with all drives off; no clearing pass.
module four_floor_elevator_controller_unit #(
	parameter int TIMER_BITS = ffec_pkg::TIMER_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ffec_cmd_if.sink                    cmd,
	ffec_res_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffec_pkg::ADDR_W-1:0] paddr,
	input  logic [ffec_pkg::DATA_W-1:0] pwdata,
	output logic [ffec_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int CMP_W = (TIMER_BITS > ffec_pkg::CFG_W) ? TIMER_BITS : ffec_pkg::CFG_W;

	// configuration
	logic [ffec_pkg::CFG_W-1:0]  pre_close_q, door_time_q, travel_q, dwell_q, flow_period_q;
	logic [ffec_pkg::DUTY_W-1:0] up_duty_q, down_duty_q;
	logic [2:0]                  reg_idx;

	// input stage and handshake
	logic                          valid_s1;
	logic [ffec_pkg::BUTTON_W-1:0] button_s1;
	logic                          res_valid_q;
	logic                          advance;
	logic                          step;

	// sequencer state
	logic [ffec_pkg::FLOOR_W-1:0] floor_q, floor_d;
	logic [ffec_pkg::MASK_W-1:0]  req_q, req_d;
	ffec_pkg::phase_t             phase_q, phase_d;
	logic [ffec_pkg::DIR_W-1:0]   dir_q, dir_d;
	logic [TIMER_BITS-1:0]        timer_q, timer_d;
	logic [ffec_pkg::LED_W-1:0]   flow_bits_q, flow_bits_d;
	logic [ffec_pkg::CFG_W-1:0]   flow_timer_q, flow_timer_d;
	logic [ffec_pkg::LED_W-1:0]   led_q, led_d;
	logic                         door_on_q, door_on_d, door_open_q, door_open_d;
	logic                         motor_on_q, motor_on_d, motor_up_q, motor_up_d;
	logic [ffec_pkg::DUTY_W-1:0]  door_duty_q, door_duty_d, motor_duty_q, motor_duty_d;
	logic                         go;
	logic [ffec_pkg::MASK_W-1:0]  fbit;

	function automatic logic t_ge(input logic [TIMER_BITS-1:0] t,
			input logic [ffec_pkg::CFG_W-1:0] lim);
		return CMP_W'(t) >= CMP_W'(lim);
	endfunction

	function automatic logic [ffec_pkg::MASK_W-1:0] floor_bit(
			input logic [ffec_pkg::FLOOR_W-1:0] f);
		logic [ffec_pkg::MASK_W-1:0] r;
		r = '0;
		if (f >= ffec_pkg::FLOOR_BOTTOM && f <= ffec_pkg::FLOOR_TOP) begin
			r = ffec_pkg::MASK_W'(1) << (f - ffec_pkg::FLOOR_BOTTOM);
		end
		return r;
	endfunction

	// ---------------- apb ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_close_q   <= ffec_pkg::PRE_CLOSE_RST;
			door_time_q   <= ffec_pkg::DOOR_TIME_RST;
			travel_q      <= ffec_pkg::TRAVEL_RST;
			dwell_q       <= ffec_pkg::DWELL_RST;
			flow_period_q <= ffec_pkg::FLOW_RST;
			up_duty_q     <= ffec_pkg::UP_DUTY_RST;
			down_duty_q   <= ffec_pkg::DOWN_DUTY_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				ffec_pkg::REG_PRE_CLOSE: pre_close_q   <= pwdata[ffec_pkg::CFG_W-1:0];
				ffec_pkg::REG_DOOR_TIME: door_time_q   <= pwdata[ffec_pkg::CFG_W-1:0];
				ffec_pkg::REG_TRAVEL:    travel_q      <= pwdata[ffec_pkg::CFG_W-1:0];
				ffec_pkg::REG_DWELL:     dwell_q       <= pwdata[ffec_pkg::CFG_W-1:0];
				ffec_pkg::REG_FLOW:      flow_period_q <= pwdata[ffec_pkg::CFG_W-1:0];
				ffec_pkg::REG_UP_DUTY:   up_duty_q     <= pwdata[ffec_pkg::DUTY_W-1:0];
				ffec_pkg::REG_DOWN_DUTY: down_duty_q   <= pwdata[ffec_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ffec_pkg::REG_PRE_CLOSE: prdata = ffec_pkg::DATA_W'(pre_close_q);
			ffec_pkg::REG_DOOR_TIME: prdata = ffec_pkg::DATA_W'(door_time_q);
			ffec_pkg::REG_TRAVEL:    prdata = ffec_pkg::DATA_W'(travel_q);
			ffec_pkg::REG_DWELL:     prdata = ffec_pkg::DATA_W'(dwell_q);
			ffec_pkg::REG_FLOW:      prdata = ffec_pkg::DATA_W'(flow_period_q);
			ffec_pkg::REG_UP_DUTY:   prdata = ffec_pkg::DATA_W'(up_duty_q);
			ffec_pkg::REG_DOWN_DUTY: prdata = ffec_pkg::DATA_W'(down_duty_q);
			default:                 prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				res_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			button_s1 <= cmd.button;
		end
	end

	// ---------------- one tick of the sequencer ----------------
	always_comb begin
		floor_d      = floor_q;
		req_d        = req_q;
		phase_d      = phase_q;
		dir_d        = dir_q;
		flow_bits_d  = flow_bits_q;
		flow_timer_d = flow_timer_q;
		led_d        = led_q;
		door_on_d    = door_on_q;
		door_open_d  = door_open_q;
		motor_on_d   = motor_on_q;
		motor_up_d   = motor_up_q;
		door_duty_d  = door_duty_q;
		motor_duty_d = motor_duty_q;
		fbit         = '0;

		timer_d = (timer_q != '1) ? timer_q + 1'b1 : timer_q;

		if (phase_q == ffec_pkg::PH_IDLE) begin
			if (button_s1 != ffec_pkg::BUTTON_NONE && button_s1 <= ffec_pkg::BUTTON_MAX) begin
				if (floor_q != button_s1) begin
					req_d = req_d | (ffec_pkg::MASK_W'(1) << (button_s1 - 3'd1));
				end
				timer_d = '0;
			end
			led_d = (led_d & ffec_pkg::LED_HI) | ffec_pkg::LED_W'(req_d);
		end

		go = (req_d != '0);

		// phases move forward, and a step back ends the tick, so one ordered pass covers the chain
		if (go && phase_d == ffec_pkg::PH_IDLE) begin
			if (t_ge(timer_d, pre_close_q)) phase_d = ffec_pkg::PH_START;
			else go = 1'b0;
		end
		if (go && phase_d == ffec_pkg::PH_START) begin
			door_open_d = 1'b0;
			door_on_d   = 1'b1;
			door_duty_d = ffec_pkg::DOOR_CLOSE_DUTY;
			timer_d     = '0;
			phase_d     = ffec_pkg::PH_CLOSE;
		end
		if (go && phase_d == ffec_pkg::PH_CLOSE) begin
			if (t_ge(timer_d, door_time_q)) begin
				door_on_d = 1'b0;
				phase_d   = ffec_pkg::PH_CHOOSE;
			end else begin
				go = 1'b0;
			end
		end
		if (go && phase_d == ffec_pkg::PH_CHOOSE) begin
			fbit = floor_bit(floor_d);
			if (req_d > fbit) begin
				dir_d        = ffec_pkg::DIR_UP;
				motor_up_d   = 1'b1;
				motor_on_d   = 1'b1;
				motor_duty_d = up_duty_q;
			end else if (req_d < fbit) begin
				dir_d        = ffec_pkg::DIR_DOWN;
				motor_up_d   = 1'b0;
				motor_on_d   = 1'b1;
				motor_duty_d = down_duty_q;
			end
			timer_d      = '0;
			flow_timer_d = '1;
			phase_d      = ffec_pkg::PH_TRAVEL;
		end
		if (go && phase_d == ffec_pkg::PH_TRAVEL) begin
			if (t_ge(timer_d, travel_q)) begin
				if (dir_d == ffec_pkg::DIR_UP && floor_d < ffec_pkg::FLOOR_TOP) begin
					floor_d = floor_d + 1'b1;
				end else if (dir_d == ffec_pkg::DIR_DOWN && floor_d > ffec_pkg::FLOOR_BOTTOM) begin
					floor_d = floor_d - 1'b1;
				end
				led_d       = led_d & ffec_pkg::LED_LO;
				flow_bits_d = ffec_pkg::FLOW_START;
				phase_d     = ffec_pkg::PH_ARRIVE;
			end else begin
				go = 1'b0;
				if (flow_timer_d != '1) flow_timer_d = flow_timer_d + 1'b1;
				if (flow_timer_d >= flow_period_q) begin
					// running light: up walks right and wraps, down shows then walks left
					if (dir_d == ffec_pkg::DIR_UP) begin
						flow_bits_d = flow_bits_d >> 1;
						if (flow_bits_d == ffec_pkg::FLOW_WRAP) flow_bits_d = ffec_pkg::FLOW_TOP;
						led_d = (led_d & ffec_pkg::LED_LO) | (flow_bits_d & ffec_pkg::LED_HI);
					end else if (dir_d == ffec_pkg::DIR_DOWN) begin
						led_d = (led_d & ffec_pkg::LED_LO) | (flow_bits_d & ffec_pkg::LED_HI);
						flow_bits_d = flow_bits_d << 1;
						if (flow_bits_d == '0) flow_bits_d = ffec_pkg::FLOW_START;
					end
					flow_timer_d = '0;
				end
			end
		end
		if (go && phase_d == ffec_pkg::PH_ARRIVE) begin
			timer_d = '0;
			if ((floor_bit(floor_d) & req_d) != '0) begin
				motor_on_d  = 1'b0;
				door_open_d = 1'b1;
				door_on_d   = 1'b1;
				door_duty_d = ffec_pkg::DOOR_OPEN_DUTY;
				phase_d     = ffec_pkg::PH_OPEN;
			end else begin
				flow_timer_d = '1;
				phase_d      = ffec_pkg::PH_TRAVEL;
				go           = 1'b0;
			end
		end
		if (go && phase_d == ffec_pkg::PH_OPEN) begin
			if (t_ge(timer_d, door_time_q)) begin
				door_on_d = 1'b0;
				req_d     = req_d & ~floor_bit(floor_d);
				led_d     = (led_d & ffec_pkg::LED_HI) | ffec_pkg::LED_W'(req_d);
				phase_d   = ffec_pkg::PH_MORE;
			end else begin
				go = 1'b0;
			end
		end
		if (go && phase_d == ffec_pkg::PH_MORE) begin
			if (req_d != '0) begin
				timer_d = '0;
				phase_d = ffec_pkg::PH_DWELL;
			end else begin
				phase_d = ffec_pkg::PH_IDLE;
				go      = 1'b0;
			end
		end
		if (go && phase_d == ffec_pkg::PH_DWELL) begin
			if (t_ge(timer_d, dwell_q)) phase_d = ffec_pkg::PH_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q      <= ffec_pkg::FLOOR_BOTTOM;
			req_q        <= '0;
			phase_q      <= ffec_pkg::PH_IDLE;
			dir_q        <= ffec_pkg::DIR_NONE;
			timer_q      <= '0;
			flow_bits_q  <= ffec_pkg::FLOW_START;
			flow_timer_q <= '0;
			led_q        <= '0;
			door_on_q    <= 1'b0;
			door_open_q  <= 1'b0;
			motor_on_q   <= 1'b0;
			motor_up_q   <= 1'b0;
			door_duty_q  <= '0;
			motor_duty_q <= '0;
		end else if (step) begin
			floor_q      <= floor_d;
			req_q        <= req_d;
			phase_q      <= phase_d;
			dir_q        <= dir_d;
			timer_q      <= timer_d;
			flow_bits_q  <= flow_bits_d;
			flow_timer_q <= flow_timer_d;
			led_q        <= led_d;
			door_on_q    <= door_on_d;
			door_open_q  <= door_open_d;
			motor_on_q   <= motor_on_d;
			motor_up_q   <= motor_up_d;
			door_duty_q  <= door_duty_d;
			motor_duty_q <= motor_duty_d;
		end
	end

	// ---------------- result ----------------
	// state only moves on a step, which needs the result slot free, so it holds while stalled
	always_comb begin
		unique case (phase_q)
			ffec_pkg::PH_IDLE:   res.phase = ffec_pkg::PCODE_IDLE;
			ffec_pkg::PH_START:  res.phase = ffec_pkg::PCODE_START;
			ffec_pkg::PH_CLOSE:  res.phase = ffec_pkg::PCODE_CLOSE;
			ffec_pkg::PH_CHOOSE: res.phase = ffec_pkg::PCODE_CHOOSE;
			ffec_pkg::PH_TRAVEL: res.phase = ffec_pkg::PCODE_TRAVEL;
			ffec_pkg::PH_ARRIVE: res.phase = ffec_pkg::PCODE_ARRIVE;
			ffec_pkg::PH_OPEN:   res.phase = ffec_pkg::PCODE_OPEN;
			ffec_pkg::PH_MORE:   res.phase = ffec_pkg::PCODE_MORE;
			ffec_pkg::PH_DWELL:  res.phase = ffec_pkg::PCODE_DWELL;
			default:             res.phase = ffec_pkg::PCODE_IDLE;
		endcase
	end

	assign res.valid           = res_valid_q;
	assign res.floor           = floor_q;
	assign res.request_mask    = req_q;
	assign res.led_pattern     = led_q;
	assign res.door_pwm_on     = door_on_q;
	assign res.door_duty       = door_duty_q;
	assign res.door_open_level = door_open_q;
	assign res.motor_pwm_on    = motor_on_q;
	assign res.motor_duty      = motor_duty_q;
	assign res.motor_up_level  = motor_up_q;

endmodule
